@@ design/stack_machine_alu_core_macros.svh @@
// Assertion macros for the stack machine execution unit
`ifndef STACK_MACHINE_ALU_CORE_MACROS_SVH
`define STACK_MACHINE_ALU_CORE_MACROS_SVH
// assert that a condition holds whenever reset is released
`define SMA_ASSERT(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);
// assert that an antecedent implies a consequent on the next clock
`define SMA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

@@ design/sma_pkg.sv @@
// Package: types, command codes and constants of the stack machine execution unit
package sma_pkg;
    localparam int STACK_DEPTH = 16;
    localparam int NUM_REGS    = 16;
    localparam int SP_W        = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int RA_W        = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
    localparam logic [31:0] EMPTY_VAL = 32'hFFFF_FD66;

    localparam logic [4:0] C_PUSH = 5'd0, C_POP = 5'd1, C_ADD = 5'd2, C_SUB = 5'd3,
        C_MUL = 5'd4, C_DIV = 5'd5, C_PUSHR = 5'd6, C_POPR = 5'd7, C_SWAP = 5'd8,
        C_RADD = 5'd9, C_RSUB = 5'd10, C_RMUL = 5'd11, C_RDIV = 5'd12, C_CMP = 5'd13,
        C_INC = 5'd14, C_DEC = 5'd15, C_PEEK = 5'd16, C_READ = 5'd17;

    localparam logic [1:0] ST_OK = 2'd0, ST_DIV0 = 2'd1, ST_OVF = 2'd2, ST_UNDER = 2'd3;

    typedef struct packed {
        logic [4:0]         cmd;
        logic [3:0]         reg_a;
        logic [3:0]         reg_b;
        logic signed [31:0] value;
    } t_in;

    typedef struct packed {
        logic signed [31:0] data;
        logic               equal;
        logic               empty_res;
        logic [1:0]         status;
    } t_out;

    typedef enum logic [2:0] {
        S_IDLE, S_READ2, S_EXEC, S_DIV, S_WB2, S_OUT
    } t_state;

    typedef struct packed {
        logic        start;
        logic [31:0] num;
        logic [31:0] den;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [31:0] quo;
    } t_div_rsp;
endpackage

@@ design/sma_div.sv @@
// Iterative signed divider, one quotient bit per cycle, truncating toward zero
module sma_div import sma_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);
    logic [31:0] r_q, n_q, r_d, n_d;
    logic [32:0] r_r, n_r;
    logic [5:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy, r_neg, n_neg, r_done, n_done;
    logic [32:0] w_sh, w_diff;

    always_comb begin
        n_q = r_q; n_d = r_d; n_r = r_r; n_cnt = r_cnt; n_busy = r_busy;
        n_neg = r_neg; n_done = 1'b0;
        w_sh = {r_r[31:0], r_q[31]};
        w_diff = w_sh - {1'b0, r_d};
        if (i_req.start) begin
            n_q = i_req.num[31] ? -i_req.num : i_req.num;
            n_d = i_req.den[31] ? -i_req.den : i_req.den;
            n_r = '0; n_cnt = 6'd32; n_busy = 1'b1;
            n_neg = i_req.num[31] ^ i_req.den[31];
        end else if (r_busy) begin
            if (!w_diff[32]) begin
                n_r = w_diff; n_q = {r_q[30:0], 1'b1};
            end else begin
                n_r = w_sh; n_q = {r_q[30:0], 1'b0};
            end
            n_cnt = r_cnt - 6'd1;
            if (r_cnt == 6'd1) begin
                n_busy = 1'b0; n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_q <= n_q; r_d <= n_d; r_r <= n_r; r_neg <= n_neg;
        if (!i_rst_n) begin
            r_busy <= 1'b0; r_done <= 1'b0; r_cnt <= '0;
        end else begin
            r_busy <= n_busy; r_done <= n_done; r_cnt <= n_cnt;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_neg ? -r_q : r_q;
endmodule

@@ design/stack_machine_alu_core.sv @@
// Stack machine execution unit: stack and register file memories with a sequencer
// Sequence: one instruction at a time, stepping through idle, read, execute and
// output; swap adds a write-back state, and a divide by nonzero waits in the divider
// state. The next transfer is taken while the result register waits. Memory reads
// are registered.
// Reset: stack count and register valid bits clear at once; no clearing pass.
`include "stack_machine_alu_core_macros.svh"
module stack_machine_alu_core import sma_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  t_in  i_data,
    output logic o_valid,
    input  logic i_stall,
    output t_out o_data
);
    logic [31:0] r_stk [STACK_DEPTH];
    logic [31:0] r_rf  [NUM_REGS];
    logic [NUM_REGS-1:0] r_rfv, n_rfv;

    t_state r_st, n_st;
    t_in    r_ins, n_ins;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [31:0] r_sa, r_ra, n_sa, n_ra;
    logic [31:0] r_srd, r_rrd;
    logic        r_rvalid;
    t_out   r_out, n_out;
    logic   r_ov, n_ov;
    t_out   r_res, n_res;

    // memory ports
    logic [SP_W-1:0] w_saddr, w_swaddr;
    logic [RA_W-1:0] w_raddr, w_rwaddr;
    logic            w_swe, w_rwe;
    logic [31:0]     w_swd, w_rwd;
    logic            w_ra_in, w_rb_in, w_rwv;
    t_div_req        w_dreq;
    t_div_rsp        w_drsp;

    sma_div u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(w_dreq), .o_rsp(w_drsp));

    assign w_ra_in = (32'(r_ins.reg_a) < NUM_REGS);
    assign w_rb_in = (32'(r_ins.reg_b) < NUM_REGS);

    always_ff @(posedge i_clk) begin
        r_srd <= r_stk[w_saddr];
        r_rrd <= r_rf[w_raddr];
        r_rvalid <= r_rfv[w_raddr];
        if (w_swe) r_stk[w_swaddr] <= w_swd;
        if (w_rwe) r_rf[w_rwaddr] <= w_rwd;
    end

    assign o_stall = (r_st != S_IDLE);
    assign o_valid = r_ov;
    assign o_data  = r_out;

    always_comb begin
        n_st = r_st;
        case (r_st)
            S_IDLE:  if (i_valid && !o_stall) n_st = S_READ2;
            S_READ2: n_st = S_EXEC;
            S_EXEC:  n_st = w_dreq.start ? S_DIV :
                            (r_ins.cmd == C_SWAP) ? S_WB2 : S_OUT;
            S_DIV:   if (w_drsp.done) n_st = S_OUT;
            S_WB2:   n_st = S_OUT;
            S_OUT:   if (!r_ov || !i_stall) n_st = S_IDLE;
            default: n_st = S_IDLE;
        endcase
    end

    function automatic logic [31:0] rf_val(input logic v, input logic [31:0] d,
                                           input logic inr);
        return (v && inr) ? d : 32'd0;
    endfunction

    always_comb begin
        n_ins = r_ins; n_cnt = r_cnt; n_sa = r_sa; n_ra = r_ra;
        n_rfv = r_rfv; n_res = r_res; n_out = r_out; n_ov = r_ov;
        w_saddr = '0; w_raddr = '0; w_swe = 1'b0; w_swaddr = '0; w_swd = '0;
        w_rwe = 1'b0; w_rwaddr = '0; w_rwd = '0; w_rwv = 1'b0;
        w_dreq = '0;
        if (r_ov && !i_stall) n_ov = 1'b0;
        case (r_st)
            S_IDLE: begin
                n_ins = i_data;
                // first reads: top of stack and reg_a
                w_saddr = SP_W'(r_cnt - CNT_W'(1));
                w_raddr = i_data.reg_a[RA_W-1:0];
            end
            S_READ2: begin
                n_sa = r_srd;
                n_ra = rf_val(r_rvalid, r_rrd, w_ra_in);
                w_saddr = SP_W'(r_cnt - CNT_W'(2));
                w_raddr = r_ins.reg_b[RA_W-1:0];
            end
            S_EXEC: begin : ex
                logic [31:0] t, s, x, y, rv;
                logic        und, pushed;
                logic [1:0]  st;
                logic [31:0] dat;
                logic        eq;
                x = r_ra;
                y = rf_val(r_rvalid, r_rrd, w_rb_in);
                t = (r_cnt >= 1) ? r_sa : EMPTY_VAL;
                s = (r_cnt >= 2) ? r_srd : EMPTY_VAL;
                und = 1'b0; st = ST_OK; dat = '0; eq = 1'b0; pushed = 1'b0; rv = '0;
                n_sa = t;
                case (r_ins.cmd)
                    C_PUSH, C_PUSHR: begin
                        if (r_cnt >= CNT_W'(STACK_DEPTH)) st = ST_OVF;
                        else begin
                            w_swe = 1'b1; w_swaddr = r_cnt[SP_W-1:0];
                            w_swd = (r_ins.cmd == C_PUSH) ? r_ins.value : x;
                            n_cnt = r_cnt + CNT_W'(1);
                        end
                    end
                    C_POP, C_POPR: begin
                        dat = t; und = (r_cnt == 0);
                        if (r_cnt != 0) n_cnt = r_cnt - CNT_W'(1);
                        if (r_ins.cmd == C_POPR && w_ra_in) begin
                            w_rwe = 1'b1; w_rwaddr = r_ins.reg_a[RA_W-1:0]; w_rwd = t;
                            w_rwv = 1'b1;
                        end
                    end
                    C_ADD, C_SUB, C_MUL, C_DIV: begin
                        und = (r_cnt < 2);
                        n_cnt = (r_cnt >= 2) ? r_cnt - CNT_W'(2) : '0;
                        case (r_ins.cmd)
                            C_ADD: begin rv = s + t; pushed = 1'b1; end
                            C_SUB: begin rv = s - t; pushed = 1'b1; end
                            C_MUL: begin rv = s * t; pushed = 1'b1; end
                            default: begin
                                if (t == 0) st = ST_DIV0;
                                else begin
                                    w_dreq.start = 1'b1; w_dreq.num = s; w_dreq.den = t;
                                end
                            end
                        endcase
                        if (pushed) begin
                            w_swe = 1'b1;
                            w_swaddr = SP_W'((r_cnt >= 2) ? r_cnt - CNT_W'(2) : '0);
                            w_swd = rv;
                            n_cnt = ((r_cnt >= 2) ? r_cnt - CNT_W'(2) : '0) + CNT_W'(1);
                        end
                    end
                    C_SWAP: begin
                        if (w_ra_in) begin
                            w_rwe = 1'b1; w_rwaddr = r_ins.reg_a[RA_W-1:0]; w_rwd = y;
                            w_rwv = 1'b1;
                        end
                    end
                    C_RADD, C_RSUB, C_RMUL, C_RDIV: begin
                        case (r_ins.cmd)
                            C_RADD: rv = x + y;
                            C_RSUB: rv = x - y;
                            C_RMUL: rv = x * y;
                            default: rv = x;
                        endcase
                        if (r_ins.cmd == C_RDIV) begin
                            if (y == 0) st = ST_DIV0;
                            else begin
                                w_dreq.start = 1'b1; w_dreq.num = x; w_dreq.den = y;
                            end
                        end else if (w_ra_in) begin
                            w_rwe = 1'b1; w_rwaddr = r_ins.reg_a[RA_W-1:0]; w_rwd = rv;
                            w_rwv = 1'b1;
                        end
                    end
                    C_CMP:  eq = (x == r_ins.value);
                    C_INC, C_DEC: begin
                        if (w_ra_in) begin
                            w_rwe = 1'b1; w_rwaddr = r_ins.reg_a[RA_W-1:0];
                            w_rwd = (r_ins.cmd == C_INC) ? x + 32'd1 : x - 32'd1;
                            w_rwv = 1'b1;
                        end
                    end
                    C_PEEK: begin dat = t; und = (r_cnt == 0); end
                    C_READ: dat = x;
                    default: ;
                endcase
                if (und && st == ST_OK) st = ST_UNDER;
                n_res.data = dat; n_res.equal = eq; n_res.status = st;
                n_res.empty_res = 1'b0;
            end
            S_DIV: begin
                if (w_drsp.done) begin
                    if (r_ins.cmd == C_DIV) begin
                        w_swe = 1'b1; w_swaddr = r_cnt[SP_W-1:0]; w_swd = w_drsp.quo;
                        n_cnt = r_cnt + CNT_W'(1);
                    end else if (w_ra_in) begin
                        w_rwe = 1'b1; w_rwaddr = r_ins.reg_a[RA_W-1:0]; w_rwd = w_drsp.quo;
                        w_rwv = 1'b1;
                    end
                end
            end
            S_WB2: begin
                if (w_rb_in) begin
                    w_rwe = 1'b1; w_rwaddr = r_ins.reg_b[RA_W-1:0]; w_rwd = r_ra;
                    w_rwv = 1'b1;
                end
            end
            S_OUT: begin
                if (!r_ov || !i_stall) begin
                    n_out = r_res; n_out.empty_res = (r_cnt == 0); n_ov = 1'b1;
                end
            end
            default: ;
        endcase
        if (w_rwv) n_rfv[w_rwaddr] = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        r_ins <= n_ins; r_sa <= n_sa; r_ra <= n_ra;
        r_res <= n_res; r_out <= n_out;
        if (!i_rst_n) begin
            r_st <= S_IDLE; r_cnt <= '0; r_rfv <= '0; r_ov <= 1'b0;
        end else begin
            r_st <= n_st; r_cnt <= n_cnt; r_rfv <= n_rfv; r_ov <= n_ov;
        end
    end

    `SMA_ASSERT(a_cnt_range, r_cnt <= CNT_W'(STACK_DEPTH), "stack count beyond depth")
    `SMA_ASSERT(a_no_accept_busy, !(r_st != S_IDLE && !o_stall), "accept while busy")
    `SMA_ASSERT_NEXT(a_read_follows, r_st == S_IDLE && i_valid && !o_stall, r_st == S_READ2, "accepted transfer did not start")
endmodule
